### rtl/hpq_pkg.sv
`default_nettype none
package hpq_pkg;

  localparam int unsigned HEAP_DEPTH_DEFAULT = 128;
  localparam int unsigned VALUE_W            = 32;
  localparam int unsigned STATUS_W           = 2;
  localparam int unsigned COUNT_OUT_W        = 8;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                      insert_en;
    logic                      remove_en;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/hpq_if.sv
`default_nettype none
interface hpq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic signed [hpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface hpq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [hpq_pkg::VALUE_W-1:0]     removed_value;
  logic        [hpq_pkg::STATUS_W-1:0]    status;
  logic        [hpq_pkg::COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output removed_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input entry_count,
                  output ready);
endinterface
`default_nettype wire

### rtl/max_heap_priority_queue.sv
`default_nettype none
// The result of an accepted item is on the output register in the cycle after acceptance.
// Throughput: 1 item per cycle; a stalled result holds the input only when not taken.
// Entries sit sorted in HEAP_DEPTH cells; an insert or remove that succeeds shifts them.
// Reset clears the entry count and the output valid; cell contents need no reset.
module max_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH = hpq_pkg::HEAP_DEPTH_DEFAULT
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  hpq_in_if.sink     in_i,
  hpq_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(HEAP_DEPTH + 1);

  logic [CntW-1:0]                      count_q, count_d;
  logic                                 out_valid_q;
  logic signed [hpq_pkg::VALUE_W-1:0]   removed_q, removed_d;
  hpq_pkg::status_e                     status_q, status_d;
  logic                                 accept;
  logic                                 full;
  logic                                 empty;
  hpq_pkg::cmd_t                        cmd;
  logic signed [hpq_pkg::VALUE_W-1:0]   cell_val [HEAP_DEPTH];
  logic                                 cell_ge  [HEAP_DEPTH];
  logic [CntW+hpq_pkg::COUNT_OUT_W-1:0] count_wide;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CntW'(HEAP_DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    cmd.insert_en = accept && (in_i.func == hpq_pkg::FUNC_INSERT) && !full;
    cmd.remove_en = accept && (in_i.func == hpq_pkg::FUNC_REMOVE) && !empty;
    cmd.value     = in_i.value;
  end

  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    logic                               prev_ge;
    logic signed [hpq_pkg::VALUE_W-1:0] prev_val;
    logic signed [hpq_pkg::VALUE_W-1:0] next_val;
    if (i == 0) begin : g_head
      assign prev_ge  = 1'b1;
      assign prev_val = in_i.value;
    end else begin : g_body
      assign prev_ge  = cell_ge[i-1];
      assign prev_val = cell_val[i-1];
    end
    if (i == HEAP_DEPTH - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_link
      assign next_val = cell_val[i+1];
    end
    hpq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occ_i      (CntW'(i) < count_q),
      .prev_ge_i  (prev_ge),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .ge_o       (cell_ge[i]),
      .val_o      (cell_val[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    removed_d = removed_q;
    status_d  = status_q;
    if (accept) begin
      removed_d = '0;
      status_d  = hpq_pkg::STATUS_OK;
      if (in_i.func == hpq_pkg::FUNC_INSERT) begin
        if (full) begin
          status_d = hpq_pkg::STATUS_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          status_d = hpq_pkg::STATUS_EMPTY;
        end else begin
          removed_d = cell_val[0];
          count_d   = count_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    status_q  <= status_d;
  end

  assign count_wide          = {{hpq_pkg::COUNT_OUT_W{1'b0}}, count_q};
  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = removed_q;
  assign out_o.status        = status_q;
  assign out_o.entry_count   = count_wide[hpq_pkg::COUNT_OUT_W-1:0];

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(HEAP_DEPTH))
    else $error("entry count above depth");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert_en |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow count");

  a_removed_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.remove_en |=> removed_q == $past(cell_val[0]))
    else $error("removed value is not the head cell");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.func == hpq_pkg::FUNC_REMOVE && empty)
      |=> (status_q == hpq_pkg::STATUS_EMPTY) && (removed_q == '0))
    else $error("remove on empty not flagged");

  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.insert_en && cmd.remove_en))
    else $error("insert and remove at once");

endmodule
`default_nettype wire

### rtl/hpq_cell.sv
`default_nettype none
module hpq_cell (
  input  wire                                 clk_i,
  input  wire hpq_pkg::cmd_t                  cmd_i,
  input  wire                                 occ_i,
  input  wire                                 prev_ge_i,
  input  wire signed [hpq_pkg::VALUE_W-1:0]   prev_val_i,
  input  wire signed [hpq_pkg::VALUE_W-1:0]   next_val_i,
  output logic                                ge_o,
  output logic signed [hpq_pkg::VALUE_W-1:0]  val_o
);

  logic signed [hpq_pkg::VALUE_W-1:0] val_q;
  logic signed [hpq_pkg::VALUE_W-1:0] val_d;

  // keep own entry while it is not below the incoming value
  assign ge_o = occ_i && (val_q >= cmd_i.value);

  always_comb begin
    val_d = val_q;
    if (cmd_i.insert_en) begin
      if (ge_o) begin
        val_d = val_q;
      end else if (prev_ge_i) begin
        val_d = cmd_i.value;
      end else begin
        val_d = prev_val_i;
      end
    end else if (cmd_i.remove_en) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule
`default_nettype wire
